>>> hw/rtl/mams_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and axis limit tables for the five-axis move sequencer.
package mams_pkg;

    localparam int NUM_AXES_DEF  = 5;
    localparam int FRAC_BITS_DEF = 4;
    localparam int MAX_AXES      = 5;
    localparam int MANUAL_AXES   = 3;

    localparam int CMD_W     = 3;
    localparam int AX_W      = 3;
    localparam int SPEED_W   = 12;
    localparam int TARGET_W  = 16;
    localparam int DIR_W     = 2;
    localparam int OUT_POS_W = 16;
    localparam int STEP_W    = SPEED_W + 1;
    // Scaled limits reach 200 * 2^FRAC_BITS plus one step, so positions carry two extra bits.
    localparam int POS_W     = 18;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_MAX  = 2'd1;

    localparam logic [AX_W-1:0] AXIS_X     = 3'd0;
    localparam logic [AX_W-1:0] AXIS_Y     = 3'd1;
    localparam logic [AX_W-1:0] AXIS_Z     = 3'd2;
    localparam logic [AX_W-1:0] AXIS_COL_H = 3'd3;
    localparam logic [AX_W-1:0] AXIS_COL_V = 3'd4;

    localparam int LIM_XZ_MAX  = 200;
    localparam int LIM_XZ_MIN  = 0;
    localparam int LIM_Y_MAX   = 110;
    localparam int LIM_Y_MIN   = -110;
    localparam int LIM_COL_MAX = 100;
    localparam int LIM_COL_MIN = 0;
    localparam int ORG_XZ      = 100;
    localparam int ORG_Y       = 0;
    localparam int ORG_COL     = 10;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [STEP_W-1:0] step_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOVE_TO    = 3'd0,
        CMD_CONTINUOUS = 3'd1,
        CMD_TICK       = 3'd2,
        CMD_SET_MANUAL = 3'd3,
        CMD_QUERY      = 3'd4,
        CMD_RESET      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ACK        = 3'd0,
        KIND_REJECTED   = 3'd1,
        KIND_POSITION   = 3'd2,
        KIND_STARTED    = 3'd3,
        KIND_STOPPED    = 3'd4,
        KIND_RESET_DONE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        RSN_NONE    = 3'd0,
        RSN_MANUAL  = 3'd1,
        RSN_TARGET  = 3'd2,
        RSN_CURRENT = 3'd3,
        RSN_SPEED   = 3'd4
    } reason_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_TMAX,
        S_CHK_TMIN,
        S_CHK_PMAX,
        S_CHK_PMIN,
        S_REJECT,
        S_ARM,
        S_START,
        S_TICK_SEL,
        S_TICK_ADD,
        S_TICK_CMP,
        S_TICK_STOP,
        S_FLUSH
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic                         last;
        reason_t                      reason;
        logic signed [OUT_POS_W-1:0]  position;
        logic [AX_W-1:0]              axis;
        kind_t                        kind;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    function automatic pos_t scale(input int v, input int frac);
        return pos_t'(v * (1 << frac));
    endfunction

    function automatic pos_t lim_max_s(input logic [AX_W-1:0] a, input int frac);
        pos_t v;
        case (a)
            AXIS_X, AXIS_Z:         v = scale(LIM_XZ_MAX, frac);
            AXIS_Y:                 v = scale(LIM_Y_MAX, frac);
            AXIS_COL_H, AXIS_COL_V: v = scale(LIM_COL_MAX, frac);
            default:                v = '0;
        endcase
        return v;
    endfunction

    function automatic pos_t lim_min_s(input logic [AX_W-1:0] a, input int frac);
        pos_t v;
        case (a)
            AXIS_X, AXIS_Z:         v = scale(LIM_XZ_MIN, frac);
            AXIS_Y:                 v = scale(LIM_Y_MIN, frac);
            AXIS_COL_H, AXIS_COL_V: v = scale(LIM_COL_MIN, frac);
            default:                v = '0;
        endcase
        return v;
    endfunction

    function automatic pos_t org_s(input logic [AX_W-1:0] a, input int frac);
        pos_t v;
        case (a)
            AXIS_X, AXIS_Z:         v = scale(ORG_XZ, frac);
            AXIS_Y:                 v = scale(ORG_Y, frac);
            AXIS_COL_H, AXIS_COL_V: v = scale(ORG_COL, frac);
            default:                v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/mams_alu.sv
`timescale 1ns / 1ps
// Shared adder and subtractor used for every limit check and position step.
module mams_alu (
    input  mams_pkg::alu_op_t           op,
    input  mams_pkg::pos_t              a,
    input  mams_pkg::pos_t              b,
    output logic signed [mams_pkg::POS_W:0] res
);

    logic signed [mams_pkg::POS_W:0] a_ext;
    logic signed [mams_pkg::POS_W:0] b_ext;

    assign a_ext = (mams_pkg::POS_W + 1)'(a);
    assign b_ext = (mams_pkg::POS_W + 1)'(b);
    assign res   = (op == mams_pkg::ALU_ADD) ? (a_ext + b_ext) : (a_ext - b_ext);

endmodule

>>> hw/rtl/mams_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer with the axis state registers, driving the shared ALU.
module mams_ctrl #(
    parameter int NUM_AXES  = mams_pkg::NUM_AXES_DEF,
    parameter int FRAC_BITS = mams_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mams_pkg::CMD_W-1:0]           in_cmd,
    input  logic [mams_pkg::AX_W-1:0]            in_axis,
    input  logic [mams_pkg::SPEED_W-1:0]         in_speed,
    input  logic signed [mams_pkg::TARGET_W-1:0] in_target,
    input  logic [mams_pkg::DIR_W-1:0]           in_dir,
    input  logic                                 in_manual,
    input  logic                                 out_free,
    output mams_pkg::push_t                      push
);

    localparam int NA    = (NUM_AXES < mams_pkg::MAX_AXES) ? NUM_AXES : mams_pkg::MAX_AXES;
    localparam int NMAN  = (NA < mams_pkg::MANUAL_AXES) ? NA : mams_pkg::MANUAL_AXES;
    localparam int IDX_W = (NA > 1) ? $clog2(NA) : 1;

    mams_pkg::state_t state_reg, state_next;

    mams_pkg::pos_t  pos_reg  [NA];
    mams_pkg::pos_t  pos_next [NA];
    mams_pkg::pos_t  tgt_reg  [NA];
    mams_pkg::pos_t  tgt_next [NA];
    mams_pkg::step_t step_reg [NA];
    mams_pkg::step_t step_next[NA];
    logic [NA-1:0]   act_reg, act_next;
    logic [NA-1:0]   stop_reg, stop_next;
    logic [NMAN-1:0] man_reg, man_next;

    logic [mams_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [mams_pkg::AX_W-1:0]    ax_reg, ax_next;
    logic [mams_pkg::SPEED_W-1:0] speed_reg, speed_next;
    mams_pkg::pos_t               dest_reg, dest_next;
    logic [mams_pkg::DIR_W-1:0]   dir_reg, dir_next;
    logic                         manual_reg, manual_next;
    mams_pkg::reason_t            reason_reg, reason_next;
    mams_pkg::pos_t               sum_reg, sum_next;
    mams_pkg::result_t            pend_reg, pend_next;
    logic                         pend_valid_reg, pend_valid_next;

    mams_pkg::alu_op_t               alu_op;
    mams_pkg::pos_t                  alu_a;
    mams_pkg::pos_t                  alu_b;
    logic signed [mams_pkg::POS_W:0] alu_res;

    logic [IDX_W-1:0]  cur;
    logic              ax_ok;
    logic              is_xyz;
    logic              cur_man;
    mams_pkg::pos_t    cur_pos;
    mams_pkg::pos_t    cur_tgt;
    mams_pkg::step_t   cur_step;
    logic              cur_act;
    logic              cur_stop;
    mams_pkg::pos_t    lim_max_cur;
    mams_pkg::pos_t    lim_min_cur;
    logic              alu_neg;
    logic              tick_done;
    logic              want_emit;
    logic              can_emit;
    logic              hold;
    mams_pkg::result_t emit_res;

    mams_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign cur         = ax_reg[IDX_W-1:0];
    assign ax_ok       = ax_reg < mams_pkg::AX_W'(NA);
    assign is_xyz      = ax_reg < mams_pkg::AX_W'(mams_pkg::MANUAL_AXES);
    assign cur_pos     = pos_reg[cur];
    assign cur_tgt     = tgt_reg[cur];
    assign cur_step    = step_reg[cur];
    assign cur_act     = act_reg[cur];
    assign cur_stop    = stop_reg[cur];
    assign lim_max_cur = mams_pkg::lim_max_s(ax_reg, FRAC_BITS);
    assign lim_min_cur = mams_pkg::lim_min_s(ax_reg, FRAC_BITS);
    assign alu_neg     = alu_res[mams_pkg::POS_W];
    assign tick_done   = cur_step[mams_pkg::STEP_W-1] ? (alu_neg || (alu_res == '0)) : !alu_neg;
    assign can_emit    = !pend_valid_reg || out_free;
    assign hold        = want_emit && !can_emit;

    always_comb
    begin
        cur_man = 1'b0;
        for (int i = 0; i < NMAN; i++)
        begin
            if (ax_reg == mams_pkg::AX_W'(i))
            begin
                cur_man = man_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (!hold)
        begin
            case (state_reg)
                mams_pkg::S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_next = mams_pkg::S_DECODE;
                    end
                end
                mams_pkg::S_DECODE:
                begin
                    case (cmd_reg)
                        mams_pkg::CMD_TICK:
                        begin
                            state_next = mams_pkg::S_TICK_SEL;
                        end
                        mams_pkg::CMD_MOVE_TO:
                        begin
                            state_next = (!ax_ok || cur_man) ? mams_pkg::S_FLUSH
                                                             : mams_pkg::S_CHK_TMAX;
                        end
                        mams_pkg::CMD_CONTINUOUS:
                        begin
                            state_next = (!ax_ok || cur_man || dir_reg == mams_pkg::DIR_STOP)
                                         ? mams_pkg::S_FLUSH : mams_pkg::S_CHK_TMAX;
                        end
                        default:
                        begin
                            state_next = mams_pkg::S_FLUSH;
                        end
                    endcase
                end
                mams_pkg::S_CHK_TMAX:
                begin
                    state_next = alu_neg ? mams_pkg::S_REJECT : mams_pkg::S_CHK_TMIN;
                end
                mams_pkg::S_CHK_TMIN:
                begin
                    state_next = alu_neg ? mams_pkg::S_REJECT : mams_pkg::S_CHK_PMAX;
                end
                mams_pkg::S_CHK_PMAX:
                begin
                    state_next = alu_neg ? mams_pkg::S_REJECT : mams_pkg::S_CHK_PMIN;
                end
                mams_pkg::S_CHK_PMIN:
                begin
                    state_next = (alu_neg || speed_reg == '0) ? mams_pkg::S_REJECT
                                                              : mams_pkg::S_ARM;
                end
                mams_pkg::S_REJECT:
                begin
                    state_next = mams_pkg::S_FLUSH;
                end
                mams_pkg::S_ARM:
                begin
                    state_next = is_xyz ? mams_pkg::S_START : mams_pkg::S_FLUSH;
                end
                mams_pkg::S_START:
                begin
                    state_next = mams_pkg::S_FLUSH;
                end
                mams_pkg::S_TICK_SEL:
                begin
                    if (!ax_ok)
                    begin
                        state_next = mams_pkg::S_FLUSH;
                    end
                    else if (cur_act && !cur_stop)
                    begin
                        state_next = mams_pkg::S_TICK_ADD;
                    end
                end
                mams_pkg::S_TICK_ADD:
                begin
                    state_next = mams_pkg::S_TICK_CMP;
                end
                mams_pkg::S_TICK_CMP:
                begin
                    state_next = (tick_done && is_xyz) ? mams_pkg::S_TICK_STOP
                                                       : mams_pkg::S_TICK_SEL;
                end
                mams_pkg::S_TICK_STOP:
                begin
                    state_next = mams_pkg::S_TICK_SEL;
                end
                mams_pkg::S_FLUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        state_next = mams_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_next = mams_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        tgt_next        = tgt_reg;
        step_next       = step_reg;
        act_next        = act_reg;
        stop_next       = stop_reg;
        man_next        = man_reg;
        cmd_next        = cmd_reg;
        ax_next         = ax_reg;
        speed_next      = speed_reg;
        dest_next       = dest_reg;
        dir_next        = dir_reg;
        manual_next     = manual_reg;
        reason_next     = reason_reg;
        sum_next        = sum_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        in_ready        = 1'b0;
        alu_op          = mams_pkg::ALU_SUB;
        alu_a           = cur_pos;
        alu_b           = dest_reg;
        want_emit       = 1'b0;
        push            = '0;

        emit_res.last     = 1'b0;
        emit_res.reason   = mams_pkg::RSN_NONE;
        emit_res.position = ax_ok ? cur_pos[mams_pkg::OUT_POS_W-1:0] : '0;
        emit_res.axis     = ax_reg;
        emit_res.kind     = mams_pkg::KIND_ACK;

        case (state_reg)
            mams_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next    = in_cmd;
                    ax_next     = in_axis;
                    speed_next  = in_speed;
                    dest_next   = mams_pkg::pos_t'(in_target);
                    dir_next    = in_dir;
                    manual_next = in_manual;
                end
            end
            mams_pkg::S_DECODE:
            begin
                case (cmd_reg)
                    mams_pkg::CMD_TICK:
                    begin
                        ax_next = '0;
                    end
                    mams_pkg::CMD_RESET:
                    begin
                        want_emit         = 1'b1;
                        emit_res.kind     = mams_pkg::KIND_RESET_DONE;
                        emit_res.axis     = '0;
                        emit_res.position = '0;
                        if (can_emit)
                        begin
                            for (int i = 0; i < NMAN; i++)
                            begin
                                pos_next[i] = mams_pkg::org_s(mams_pkg::AX_W'(i), FRAC_BITS);
                            end
                            stop_next = '0;
                            man_next  = '0;
                        end
                    end
                    mams_pkg::CMD_MOVE_TO, mams_pkg::CMD_CONTINUOUS,
                    mams_pkg::CMD_SET_MANUAL, mams_pkg::CMD_QUERY:
                    begin
                        if (!ax_ok)
                        begin
                            want_emit = 1'b1;
                        end
                        else if (cmd_reg == mams_pkg::CMD_SET_MANUAL)
                        begin
                            want_emit = 1'b1;
                            if (can_emit)
                            begin
                                for (int i = 0; i < NMAN; i++)
                                begin
                                    if (ax_reg == mams_pkg::AX_W'(i))
                                    begin
                                        man_next[i] = manual_reg;
                                    end
                                end
                            end
                        end
                        else if (cmd_reg == mams_pkg::CMD_QUERY)
                        begin
                            want_emit     = 1'b1;
                            emit_res.kind = mams_pkg::KIND_POSITION;
                        end
                        else if (cmd_reg == mams_pkg::CMD_CONTINUOUS
                                 && dir_reg == mams_pkg::DIR_STOP)
                        begin
                            want_emit = 1'b1;
                            if (can_emit)
                            begin
                                stop_next[cur] = 1'b1;
                            end
                        end
                        else
                        begin
                            if (cmd_reg == mams_pkg::CMD_CONTINUOUS)
                            begin
                                dest_next = (dir_reg == mams_pkg::DIR_MAX) ? lim_max_cur
                                                                            : lim_min_cur;
                            end
                            if (cur_man)
                            begin
                                want_emit       = 1'b1;
                                emit_res.kind   = mams_pkg::KIND_REJECTED;
                                emit_res.reason = mams_pkg::RSN_MANUAL;
                            end
                        end
                    end
                    default:
                    begin
                        want_emit = 1'b0;
                    end
                endcase
            end
            mams_pkg::S_CHK_TMAX:
            begin
                alu_a       = lim_max_cur;
                alu_b       = dest_reg;
                reason_next = mams_pkg::RSN_TARGET;
            end
            mams_pkg::S_CHK_TMIN:
            begin
                alu_a       = dest_reg;
                alu_b       = lim_min_cur;
                reason_next = mams_pkg::RSN_TARGET;
            end
            mams_pkg::S_CHK_PMAX:
            begin
                alu_a       = lim_max_cur;
                alu_b       = cur_pos;
                reason_next = mams_pkg::RSN_CURRENT;
            end
            mams_pkg::S_CHK_PMIN:
            begin
                alu_a       = cur_pos;
                alu_b       = lim_min_cur;
                reason_next = alu_neg ? mams_pkg::RSN_CURRENT : mams_pkg::RSN_SPEED;
            end
            mams_pkg::S_REJECT:
            begin
                want_emit       = 1'b1;
                emit_res.kind   = mams_pkg::KIND_REJECTED;
                emit_res.reason = reason_reg;
            end
            mams_pkg::S_ARM:
            begin
                alu_a     = cur_pos;
                alu_b     = dest_reg;
                want_emit = 1'b1;
                if (can_emit)
                begin
                    tgt_next[cur]  = dest_reg;
                    step_next[cur] = alu_neg ? mams_pkg::step_t'({1'b0, speed_reg})
                                             : -mams_pkg::step_t'({1'b0, speed_reg});
                    act_next[cur]  = 1'b1;
                end
            end
            mams_pkg::S_START:
            begin
                want_emit     = 1'b1;
                emit_res.kind = mams_pkg::KIND_STARTED;
            end
            mams_pkg::S_TICK_SEL:
            begin
                if (ax_ok)
                begin
                    if (!cur_act)
                    begin
                        ax_next = ax_reg + mams_pkg::AX_W'(1);
                    end
                    else if (cur_stop)
                    begin
                        want_emit     = is_xyz;
                        emit_res.kind = mams_pkg::KIND_STOPPED;
                        if (can_emit)
                        begin
                            act_next[cur]  = 1'b0;
                            stop_next[cur] = 1'b0;
                            ax_next        = ax_reg + mams_pkg::AX_W'(1);
                        end
                    end
                end
            end
            mams_pkg::S_TICK_ADD:
            begin
                alu_op   = mams_pkg::ALU_ADD;
                alu_a    = cur_pos;
                alu_b    = mams_pkg::pos_t'(cur_step);
                sum_next = alu_res[mams_pkg::POS_W-1:0];
            end
            mams_pkg::S_TICK_CMP:
            begin
                alu_a             = sum_reg;
                alu_b             = cur_tgt;
                want_emit         = 1'b1;
                emit_res.kind     = mams_pkg::KIND_POSITION;
                emit_res.position = tick_done ? cur_tgt[mams_pkg::OUT_POS_W-1:0]
                                              : sum_reg[mams_pkg::OUT_POS_W-1:0];
                if (can_emit)
                begin
                    pos_next[cur] = tick_done ? cur_tgt : sum_reg;
                    if (tick_done)
                    begin
                        act_next[cur]  = 1'b0;
                        stop_next[cur] = 1'b0;
                    end
                    if (!(tick_done && is_xyz))
                    begin
                        ax_next = ax_reg + mams_pkg::AX_W'(1);
                    end
                end
            end
            mams_pkg::S_TICK_STOP:
            begin
                want_emit     = 1'b1;
                emit_res.kind = mams_pkg::KIND_STOPPED;
                if (can_emit)
                begin
                    ax_next = ax_reg + mams_pkg::AX_W'(1);
                end
            end
            mams_pkg::S_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    push.valid      = 1'b1;
                    push.res        = pend_reg;
                    push.res.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                want_emit = 1'b0;
            end
        endcase

        if (want_emit && can_emit)
        begin
            push.valid      = pend_valid_reg;
            push.res        = pend_reg;
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mams_pkg::S_IDLE;
            pend_valid_reg <= 1'b0;
            act_reg        <= '0;
            stop_reg       <= '0;
            man_reg        <= '0;
            for (int i = 0; i < NA; i++)
            begin
                pos_reg[i]  <= mams_pkg::org_s(mams_pkg::AX_W'(i), FRAC_BITS);
                tgt_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            act_reg        <= act_next;
            stop_reg       <= stop_next;
            man_reg        <= man_next;
            pos_reg        <= pos_next;
            tgt_reg        <= tgt_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ax_reg     <= ax_next;
        speed_reg  <= speed_next;
        dest_reg   <= dest_next;
        dir_reg    <= dir_next;
        manual_reg <= manual_next;
        reason_reg <= reason_next;
        sum_reg    <= sum_next;
        pend_reg   <= pend_next;
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mams_pkg::S_IDLE |-> !pend_valid_reg)
        else $error("Pending result left over while idle.");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.res.last |=> state_reg == mams_pkg::S_IDLE)
        else $error("Final result pushed but sequencer did not return to idle.");

    for (genvar g = 0; g < NA; g++)
    begin : g_axis_chk
        a_active_step: assert property (@(posedge clk) disable iff (!rst_n)
            act_reg[g] |-> step_reg[g] != '0)
            else $error("Active axis has a zero step.");

        a_pos_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
            (pos_reg[g] <= mams_pkg::lim_max_s(mams_pkg::AX_W'(g), FRAC_BITS))
            && (pos_reg[g] >= mams_pkg::lim_min_s(mams_pkg::AX_W'(g), FRAC_BITS)))
            else $error("Axis position outside its limits.");
    end
`endif

endmodule

>>> hw/rtl/multi_axis_move_sequencer_core.sv
`timescale 1ns / 1ps
// Top level of the five-axis move sequencer with stream ports and output register.
// A query, set manual, stop request or reset pushes its result from the pending register
// in flush; a move runs four limit checks in the shared ALU, then acks and ends. A waiting
// output holds the sequencer. Items are taken one at a time, the next one in idle after the
// last result. A tick runs decode, select for each idle axis, select, add and compare for
// each moving axis, stop where an X, Y or Z move ends, then end of scan, flush and idle.
// Reset: asynchronous, active low; all axes idle at their origin positions, no manual mode.
module multi_axis_move_sequencer_core #(
    parameter int NUM_AXES  = mams_pkg::NUM_AXES_DEF,
    parameter int FRAC_BITS = mams_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // axis [2:0], speed [14:3], target [30:15], direction [32:31], manual_on [33]
    input  logic [mams_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command [2:0]
    input  logic [mams_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_axis [2:0], position_out [18:3], reject_reason [21:19]
    output logic [mams_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // result_kind [2:0]
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    mams_pkg::push_t   push;
    mams_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    mams_ctrl #(
        .NUM_AXES  (NUM_AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_axis   (s_axis_tdata[2:0]),
        .in_speed  (s_axis_tdata[14:3]),
        .in_target (s_axis_tdata[30:15]),
        .in_dir    (s_axis_tdata[32:31]),
        .in_manual (s_axis_tdata[33]),
        .out_free  (out_free),
        .push      (push)
    );

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push.valid)
        begin
            out_next       = push.res;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.reason, out_reg.position, out_reg.axis};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule
